>>> rtl/core/btr_pkg.sv
// ----------------------------------------------------------------------------
// btr_pkg: shared constants and font table for the bitmap text rasterizer
// Holds the 5x7 column-major glyph table and the fixed geometry of the font.
// ----------------------------------------------------------------------------
package btr_pkg;

	localparam int GlyphCols   = 5;
	localparam int GlyphRows   = 7;
	localparam int GlyphBits   = GlyphCols * GlyphRows;
	localparam int CharAdvance = 6;
	localparam int CoordW      = 16;
	localparam int ScaleW      = 4;
	localparam int OffW        = 7;   // holds 7 * 15
	localparam logic [CoordW-1:0] CoordMax = 16'h7FFF;

	// Columns packed {col4, col3, col2, col1, col0}; bit r of a column is row r.
	// Codes outside the table return all zeros (blank glyph).
	function automatic logic [8*GlyphCols-1:0] font_columns(input logic [7:0] code);
		logic [8*GlyphCols-1:0] c;
		begin
			case (code)
				8'h25: c = {8'h62, 8'h64, 8'h08, 8'h13, 8'h23};
				8'h2B: c = {8'h08, 8'h08, 8'h3E, 8'h08, 8'h08};
				8'h2D: c = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
				8'h2E: c = {8'h00, 8'h00, 8'h60, 8'h60, 8'h00};
				8'h2F: c = {8'h00, 8'h01, 8'h06, 8'h18, 8'h60};
				8'h30: c = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
				8'h31: c = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
				8'h32: c = {8'h46, 8'h49, 8'h49, 8'h51, 8'h62};
				8'h33: c = {8'h36, 8'h49, 8'h49, 8'h49, 8'h22};
				8'h34: c = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
				8'h35: c = {8'h31, 8'h49, 8'h49, 8'h49, 8'h2F};
				8'h36: c = {8'h32, 8'h49, 8'h49, 8'h49, 8'h3E};
				8'h37: c = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
				8'h38: c = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
				8'h39: c = {8'h3E, 8'h49, 8'h49, 8'h49, 8'h26};
				8'h3A: c = {8'h00, 8'h00, 8'h36, 8'h36, 8'h00};
				8'h41: c = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
				8'h42: c = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
				8'h43: c = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
				8'h44: c = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
				8'h45: c = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
				8'h46: c = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
				8'h47: c = {8'h7A, 8'h49, 8'h49, 8'h41, 8'h3E};
				8'h48: c = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
				8'h49: c = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
				8'h4A: c = {8'h01, 8'h3F, 8'h41, 8'h40, 8'h20};
				8'h4B: c = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7F};
				8'h4C: c = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
				8'h4D: c = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
				8'h4E: c = {8'h7F, 8'h10, 8'h08, 8'h04, 8'h7F};
				8'h4F: c = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
				8'h50: c = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
				8'h51: c = {8'h5E, 8'h21, 8'h51, 8'h41, 8'h3E};
				8'h52: c = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
				8'h53: c = {8'h31, 8'h49, 8'h49, 8'h49, 8'h46};
				8'h54: c = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
				8'h55: c = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
				8'h56: c = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
				8'h57: c = {8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F};
				8'h58: c = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
				8'h59: c = {8'h03, 8'h04, 8'h78, 8'h04, 8'h03};
				8'h5A: c = {8'h43, 8'h45, 8'h49, 8'h51, 8'h61};
				default: c = '0;
			endcase
			return c;
		end
	endfunction

endpackage

>>> rtl/core/bitmap_text_rasterizer.sv
// ----------------------------------------------------------------------------
// bitmap_text_rasterizer: 5x7 font character generator
// Turns characters into square fill rectangles, one per set font bit.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one character per transaction. tuser = string_start; when
//   set, the origin, color and scale in tdata are latched (scale 0 -> 1).
//   Master stream: one rectangle per transaction. tuser = pixel_present,
//   tlast marks the final rectangle of a character. A blank glyph (codes
//   outside space..'Z' or without a table entry) gives one transaction with
//   pixel_present low and tlast high.
//   Timing: a character passes the advance step, then per font column a
//   column-x step and a scan of its rows; the scan stops after the last
//   set bit. A blank glyph goes from the advance step to S_BLANK, which
//   loads its one transaction; a drawn glyph loads its first rectangle from
//   S_SCAN, after S_ADV and S_COLX.
//   The steps follow from the single add-and-saturate unit that computes the
//   advance, each column x and each row y in turn.
//   s_tready is high only between characters. A stalled master side holds
//   the scan on the next set bit; the output register keeps its transaction.
//   Reset: cursor, row and color clear to 0, scale to 1, no output pending.
// ----------------------------------------------------------------------------
module bitmap_text_rasterizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// char_code[7:0], origin_x[23:8], origin_y[39:24], text_color[55:40],
	// pixel_scale[59:56], zero[63:60]
	input  logic [63:0] s_tdata,
	// string_start[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// rect_x[15:0], rect_y[31:16], rect_side[35:32], rect_color[51:36],
	// cursor_after[67:52], zero[71:68]
	output logic [71:0] m_tdata,
	// pixel_present[0]
	output logic        m_tuser,
	output logic        m_tlast
);

	localparam int CW = btr_pkg::CoordW;
	localparam int SW = btr_pkg::ScaleW;
	localparam int OW = btr_pkg::OffW;
	localparam int GB = btr_pkg::GlyphBits;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ADV   = 3'd1;
	localparam logic [2:0] S_COLX  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_BLANK = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] cursor_q, rowy_q, color_q, after_q, xcur_q;
	logic [SW-1:0] scale_q;
	logic [GB-1:0] glyph_q;
	logic [OW-1:0] x_off_q, y_off_q;
	logic [2:0]    row_q;

	logic          out_valid_q, out_present_q, out_last_q;
	logic [CW-1:0] out_x_q, out_y_q, out_after_q, out_color_q;
	logic [SW-1:0] out_side_q;

	logic          s_acc;
	logic [SW-1:0] in_scale;
	logic [8*btr_pkg::GlyphCols-1:0] font_bytes;
	logic [GB-1:0] glyph_n;
	logic [CW-1:0] unit_base, unit_res;
	logic [OW-1:0] unit_off, adv_off;
	logic [CW:0]   unit_sum;
	logic          out_free, bit_now, rest_empty, out_load;

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign in_scale = (s_tdata[59:56] == '0) ? SW'(1) : s_tdata[59:56];

	// column-major table: bit col*7+row of the scan vector
	always_comb begin
		font_bytes = btr_pkg::font_columns(s_tdata[7:0]);
		for (int c = 0; c < btr_pkg::GlyphCols; c++) begin
			for (int r = 0; r < btr_pkg::GlyphRows; r++) begin
				glyph_n[c*btr_pkg::GlyphRows + r] = font_bytes[c*8 + r];
			end
		end
	end

	assign adv_off = OW'({scale_q, 2'b00}) + OW'({scale_q, 1'b0});

	// shared add-and-saturate unit; offsets are never negative
	always_comb begin
		case (state_q)
			S_ADV: begin
				unit_base = cursor_q;
				unit_off  = adv_off;
			end
			S_COLX: begin
				unit_base = cursor_q;
				unit_off  = x_off_q;
			end
			S_SCAN: begin
				unit_base = rowy_q;
				unit_off  = y_off_q;
			end
			default: begin
				unit_base = cursor_q;
				unit_off  = '0;
			end
		endcase
		unit_sum = {unit_base[CW-1], unit_base} + {{(CW+1-OW){1'b0}}, unit_off};
		unit_res = (!unit_sum[CW] && unit_sum[CW-1]) ? btr_pkg::CoordMax : unit_sum[CW-1:0];
	end

	assign out_free   = !out_valid_q || m_tready;
	assign bit_now    = glyph_q[0];
	assign rest_empty = (glyph_q[GB-1:1] == '0);
	assign out_load   = ((state_q == S_SCAN) && bit_now && out_free) ||
	                    ((state_q == S_BLANK) && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cursor_q <= '0;
			rowy_q   <= '0;
			color_q  <= '0;
			scale_q  <= SW'(1);
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						if (s_tuser) begin
							cursor_q <= s_tdata[23:8];
							rowy_q   <= s_tdata[39:24];
							color_q  <= s_tdata[55:40];
							scale_q  <= in_scale;
						end
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					state_q <= (glyph_q == '0) ? S_BLANK : S_COLX;
				end
				S_COLX: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (!bit_now || out_free) begin
						if (rest_empty) begin
							cursor_q <= after_q;
							state_q  <= S_IDLE;
						end else if (row_q == 3'(btr_pkg::GlyphRows - 1)) begin
							state_q <= S_COLX;
						end
					end
				end
				S_BLANK: begin
					if (out_free) begin
						cursor_q <= after_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// scan datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					glyph_q <= glyph_n;
				end
			end
			S_ADV: begin
				after_q <= unit_res;
				x_off_q <= '0;
			end
			S_COLX: begin
				xcur_q  <= unit_res;
				y_off_q <= '0;
				row_q   <= '0;
			end
			S_SCAN: begin
				if (!bit_now || out_free) begin
					glyph_q <= glyph_q >> 1;
					y_off_q <= y_off_q + OW'(scale_q);
					row_q   <= row_q + 3'd1;
					if (row_q == 3'(btr_pkg::GlyphRows - 1)) begin
						x_off_q <= x_off_q + OW'(scale_q);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_side_q  <= scale_q;
			out_color_q <= color_q;
			out_after_q <= after_q;
			if (state_q == S_SCAN) begin
				out_x_q       <= xcur_q;
				out_y_q       <= unit_res;
				out_present_q <= 1'b1;
				out_last_q    <= rest_empty;
			end else begin
				out_x_q       <= cursor_q;
				out_y_q       <= rowy_q;
				out_present_q <= 1'b0;
				out_last_q    <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_after_q, out_color_q, out_side_q, out_y_q, out_x_q};
	assign m_tuser  = out_present_q;
	assign m_tlast  = out_last_q;

	a_scan_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (glyph_q != '0))
		else $error("scan running on an empty glyph");

	a_last_ends_char: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && ((state_q == S_BLANK) || rest_empty)) |=> (state_q == S_IDLE))
		else $error("character did not finish after its last rectangle");

	a_scale_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		scale_q != '0)
		else $error("latched scale is zero");

	a_side_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_side_q != '0))
		else $error("rectangle side is zero");

endmodule
